// ----- rtl/sack_pkg.sv -----
// Shared types and constants of the selective-acknowledge tracker.
`timescale 1ns / 1ps
`default_nettype none
package sack_pkg;

  localparam int WINDOW_BITS = 64;
  localparam logic [63:0] WIN_MASK = 64'(~64'd0 >> (64 - WINDOW_BITS));

  localparam logic [1:0] MODE_MARK  = 2'd0;
  localparam logic [1:0] MODE_QUERY = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [63:0] seq_num;
  } req_t;

  typedef struct packed {
    logic [63:0] ack_out;
    logic [63:0] bits_out;
    logic        seen;
    logic        tracking;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_APPLY,
    ST_SHIFT,
    ST_OUT
  } state_t;

  typedef enum logic {
    ALU_SUB,
    ALU_INC
  } alu_op_t;

  typedef struct packed {
    logic [63:0] sum;
    logic        le;
  } alu_res_t;

endpackage
`default_nettype wire

// ----- rtl/sack_alu.sv -----
// Shared 64-bit subtract, compare and increment unit of the tracker.
`timescale 1ns / 1ps
`default_nettype none
module sack_alu (
  input  wire sack_pkg::alu_op_t  op,
  input  wire logic [63:0]        a,
  input  wire logic [63:0]        b,
  output sack_pkg::alu_res_t      res
);

  logic [64:0] wide;

  always_comb begin
    unique case (op)
      sack_pkg::ALU_SUB: wide = {1'b0, a} - {1'b0, b};
      sack_pkg::ALU_INC: wide = {1'b0, a} + 65'd1;
      default:           wide = {1'b0, a};
    endcase
    res.sum = wide[63:0];
    res.le  = wide[64] | (wide[63:0] == 64'd0);
  end

endmodule
`default_nettype wire

// ----- rtl/selective_ack_tracker_core.sv -----
// Top level of the receiver-side selective-acknowledge tracker.
// The req channel takes one word per item: a mode (mark, query or clear) and a
// 64-bit sequence number. The rsp channel returns one word per item with the
// cumulative ack, the bitmap of numbers received beyond it, the query answer
// and the tracking flag, all showing the state after the item.
// One 64-bit adder is shared under a small sequencer, which takes the word,
// subtracts and compares it against the ack, applies the result and loads
// the output register. A mark that advances the ack then shifts the bitmap
// by one bit per cycle, advancing the ack once per consumed bit, before the
// output step; at most 63 bits can be consumed there, since at most 63 remain
// after the first shift. A clear, a first mark, a query before tracking or an
// unused mode skips the apply step.
// The output register decouples the channels: a new word is taken while a
// result still waits, and the sequencer holds in its final step while rsp
// is stalled with a full output register. req_stall is high while an item is
// in work. Reset is synchronous and returns the tracker to the untracked
// state with a zero ack and empty bitmap; no result is pending afterwards.
`timescale 1ns / 1ps
`default_nettype none
module selective_ack_tracker_core (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire sack_pkg::req_t req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output sack_pkg::rsp_t      rsp
);

  sack_pkg::state_t   state;
  sack_pkg::state_t   state_next;
  sack_pkg::alu_op_t  alu_op;
  sack_pkg::alu_res_t alu_res;

  logic [1:0]  mode_r;
  logic [63:0] seq_r;
  logic [63:0] diff_r;
  logic        le_r;
  logic        seen_r;
  logic [63:0] cum_ack;
  logic [63:0] held_bits;
  logic        started;
  logic [63:0] alu_a;
  logic        in_win;
  logic [5:0]  off;
  logic        rsp_free;
  logic        load_rsp;

  assign in_win   = (diff_r != 64'd0) && (diff_r <= 64'(sack_pkg::WINDOW_BITS));
  assign off      = 6'(diff_r[5:0] - 6'd1);
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign alu_a    = (alu_op == sack_pkg::ALU_SUB) ? seq_r : cum_ack;

  sack_alu u_alu (
    .op  (alu_op),
    .a   (alu_a),
    .b   (cum_ack),
    .res (alu_res)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      sack_pkg::ST_IDLE: begin
        if (req_valid) begin
          state_next = sack_pkg::ST_DIFF;
        end
      end
      sack_pkg::ST_DIFF: begin
        if ((mode_r == sack_pkg::MODE_MARK || mode_r == sack_pkg::MODE_QUERY) && started) begin
          state_next = sack_pkg::ST_APPLY;
        end else begin
          state_next = sack_pkg::ST_OUT;
        end
      end
      sack_pkg::ST_APPLY: begin
        if (mode_r == sack_pkg::MODE_MARK && !le_r && diff_r == 64'd1) begin
          state_next = sack_pkg::ST_SHIFT;
        end else begin
          state_next = sack_pkg::ST_OUT;
        end
      end
      sack_pkg::ST_SHIFT: begin
        if (!held_bits[0]) begin
          state_next = sack_pkg::ST_OUT;
        end
      end
      sack_pkg::ST_OUT: begin
        if (rsp_free) begin
          state_next = sack_pkg::ST_IDLE;
        end
      end
      default: state_next = sack_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    req_stall = (state != sack_pkg::ST_IDLE);
    alu_op    = (state == sack_pkg::ST_SHIFT) ? sack_pkg::ALU_INC : sack_pkg::ALU_SUB;
    load_rsp  = (state == sack_pkg::ST_OUT) && rsp_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sack_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == sack_pkg::ST_IDLE && req_valid) begin
      mode_r <= req.mode;
      seq_r  <= req.seq_num;
    end
    if (state == sack_pkg::ST_DIFF) begin
      diff_r <= alu_res.sum;
      le_r   <= alu_res.le;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cum_ack   <= 64'd0;
      held_bits <= 64'd0;
      started   <= 1'b0;
      seen_r    <= 1'b0;
    end else begin
      unique case (state)
        sack_pkg::ST_DIFF: begin
          seen_r <= 1'b0;
          if (mode_r == sack_pkg::MODE_CLEAR) begin
            cum_ack   <= 64'd0;
            held_bits <= 64'd0;
            started   <= 1'b0;
          end else if (mode_r == sack_pkg::MODE_MARK && !started) begin
            cum_ack   <= seq_r;
            held_bits <= 64'd0;
            started   <= 1'b1;
          end
        end
        sack_pkg::ST_APPLY: begin
          if (mode_r == sack_pkg::MODE_QUERY) begin
            seen_r <= le_r || (in_win && held_bits[off]);
          end else if (mode_r == sack_pkg::MODE_MARK && !le_r) begin
            if (diff_r == 64'd1) begin
              cum_ack   <= seq_r;
              held_bits <= (held_bits >> 1) & sack_pkg::WIN_MASK;
            end else if (in_win) begin
              held_bits <= (held_bits | (64'd1 << off)) & sack_pkg::WIN_MASK;
            end
          end
        end
        sack_pkg::ST_SHIFT: begin
          if (held_bits[0]) begin
            held_bits <= held_bits >> 1;
            cum_ack   <= alu_res.sum;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_rsp) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.ack_out  <= cum_ack;
      rsp.bits_out <= held_bits & sack_pkg::WIN_MASK;
      rsp.seen     <= seen_r;
      rsp.tracking <= started;
    end
  end

`ifndef ASSERT_OFF
  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == sack_pkg::ST_OUT)
    else $error("Result word appeared without a completed item.");

  a_window: assert property (@(posedge clk) disable iff (rst)
    (held_bits & ~sack_pkg::WIN_MASK) == 64'd0)
    else $error("Bitmap holds bits beyond the window.");

  a_shift_inc: assert property (@(posedge clk) disable iff (rst)
    (state == sack_pkg::ST_SHIFT && held_bits[0]) |=> cum_ack == $past(cum_ack) + 64'd1)
    else $error("Ack did not advance with a consumed bit.");

  a_idle_state: assert property (@(posedge clk) disable iff (rst)
    !started |-> (cum_ack == 64'd0 && held_bits == 64'd0))
    else $error("Untracked state holds a nonzero ack or bitmap.");
`endif

endmodule
`default_nettype wire
